// ===== sv/pipz_pkg.sv =====
package pipz_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_ZONES    = 32;

  localparam int unsigned VIDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned VCNT_W = VIDX_W + 1;
  localparam int unsigned ZIDX_W = $clog2(MAX_ZONES);
  localparam int unsigned ZCNT_W = ZIDX_W + 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_VTX_FULL  = 2'd1,
    ST_ZONE_FULL = 2'd2
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [3:0]         zone_flag;
  } in_t;

  typedef struct packed {
    logic [3:0] result_flag;
    logic       found;
    status_e    status;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } vtx_t;

  typedef struct packed {
    logic [VCNT_W-1:0] zstart;
    logic [VCNT_W-1:0] zend;
    logic [3:0]        flag;
  } zone_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic zone_rd;
    logic zone_next;
    logic walk_start;
    logic edge_rd;
    logic res_hit;
    logic res_miss;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zone_done;
    logic zone_empty;
    logic last_edge;
    logic pipe_busy;
    logic in_zone;
  } dp_sts_t;

endpackage

// ===== sv/point_in_polygon_zone_classifier.sv =====
// Polygon zone classifier, even-odd point-in-polygon test over a table of zones.
// Input channel (in_valid_i / in_stall_o) carries one opcode beat: clear, append
// vertex, close zone with flag, or query point. Output channel (out_valid_o /
// out_stall_i) returns exactly one result beat per input beat, in order.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes the 4-bit flag
// returned when a query point lies in no zone; it is always ready.
// For clear, append and close, the result is valid in the cycle after the
// beat is accepted. A query walks the closed zones in load order through one
// vertex-store read port and a four-stage cross-multiplication pipeline: each
// zone entry is read, an empty zone is skipped, else the edges are read in
// turn and the pipeline drains before the parity is checked; a hit, or after
// the last zone a miss, is posted once the output is free. It stops at the
// first zone that contains the point. One item is in work at a time.
// Reset (rst_ni low, asynchronous) empties the zone table and vertex store
// and sets the unknown flag to zero; no clearing pass is needed.
// The result sits in an output register; while out_stall_i holds a valid
// result, the input is stalled until that beat is taken.
module point_in_polygon_zone_classifier (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pipz_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pipz_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [3:0]      cfg_data_i
);
  import pipz_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  pipz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pipz_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/pipz_dp.sv =====
module pipz_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pipz_pkg::in_t        in_data_i,
  input  logic                 cfg_valid_i,
  input  logic [3:0]           cfg_data_i,
  input  pipz_pkg::ctrl_cmd_t  cmd_i,
  output pipz_pkg::dp_sts_t    sts_o,
  output pipz_pkg::out_t       out_data_o
);
  import pipz_pkg::*;

  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? (~v + 33'd1) : v;
    return t[31:0];
  endfunction

  function automatic logic slt(input logic n1, input logic [63:0] m1,
                               input logic n2, input logic [63:0] m2);
    logic r;
    if (n1 != n2) begin
      r = n1;
    end else if (!n1) begin
      r = m1 < m2;
    end else begin
      r = m1 > m2;
    end
    return r;
  endfunction

  vtx_t  vmem [MAX_VERTICES];
  zone_t zmem [MAX_ZONES];

  logic [VCNT_W-1:0] vcnt_q, open_start_q, vidx_q;
  logic [ZCNT_W-1:0] zcnt_q, zidx_q;
  logic [3:0]        unk_q;
  logic signed [31:0] px_q, py_q;

  zone_t zrd_q;
  vtx_t  vrd_q, prev_q;
  logic  vrd_v_q, vrd_edge_q;

  logic               s1_v_q, s1_cond_q;
  logic signed [32:0] a_q, b_q, c_q, d_q;

  logic        s2_v_q, s2_cond_q, s2_nl_q, s2_nr_q, s2_dpos_q;
  logic [31:0] am_q, bm_q, cm_q, dm_q;

  logic        s3_v_q, s3_cond_q, s3_nl_q, s3_nr_q, s3_dpos_q;
  logic [63:0] ml_q, mr_q;

  logic odd_q;
  out_t out_q;

  logic              vfull, zfull, vrd_en, lt, nl, nr, cond;
  logic [VCNT_W-1:0] zlast;
  logic [VIDX_W-1:0] vraddr;
  logic              is_append, is_close, is_query, is_other;

  assign vfull     = vcnt_q == VCNT_W'(MAX_VERTICES);
  assign zfull     = zcnt_q == ZCNT_W'(MAX_ZONES);
  assign is_append = cmd_i.accept && (in_data_i.opcode == OP_APPEND);
  assign is_close  = cmd_i.accept && (in_data_i.opcode == OP_CLOSE);
  assign is_query  = cmd_i.accept && (in_data_i.opcode == OP_QUERY);
  assign is_other  = cmd_i.accept && (in_data_i.opcode != OP_QUERY);

  // The walk primes with the zone's last vertex so the first edge closes the ring.
  assign zlast  = zrd_q.zend - VCNT_W'(1);
  assign vraddr = cmd_i.walk_start ? zlast[VIDX_W-1:0] : vidx_q[VIDX_W-1:0];
  assign vrd_en = cmd_i.walk_start || cmd_i.edge_rd;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q       <= '0;
      zcnt_q       <= '0;
      open_start_q <= '0;
      zidx_q       <= '0;
      vidx_q       <= '0;
      unk_q        <= '0;
      vrd_v_q      <= 1'b0;
      vrd_edge_q   <= 1'b0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      odd_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unk_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        case (in_data_i.opcode)
          OP_CLEAR: begin
            vcnt_q       <= '0;
            zcnt_q       <= '0;
            open_start_q <= '0;
          end
          OP_APPEND: begin
            if (!vfull) vcnt_q <= vcnt_q + VCNT_W'(1);
          end
          OP_CLOSE: begin
            if (!zfull) begin
              zcnt_q       <= zcnt_q + ZCNT_W'(1);
              open_start_q <= vcnt_q;
            end
          end
          default: zidx_q <= '0;
        endcase
      end
      if (cmd_i.zone_next) zidx_q <= zidx_q + ZCNT_W'(1);
      if (cmd_i.walk_start) begin
        vidx_q <= zrd_q.zstart;
      end else if (cmd_i.edge_rd) begin
        vidx_q <= vidx_q + VCNT_W'(1);
      end
      vrd_v_q    <= vrd_en;
      vrd_edge_q <= cmd_i.edge_rd;
      s1_v_q     <= vrd_v_q && vrd_edge_q;
      s2_v_q     <= s1_v_q;
      s3_v_q     <= s2_v_q;
      if (cmd_i.walk_start) begin
        odd_q <= 1'b0;
      end else if (s3_v_q && s3_cond_q && lt) begin
        odd_q <= !odd_q;
      end
    end
  end

  // Stores
  always_ff @(posedge clk_i) begin
    if (is_append && !vfull) begin
      vmem[vcnt_q[VIDX_W-1:0]] <= '{x: in_data_i.point_x, y: in_data_i.point_y};
    end
    if (vrd_en) begin
      vrd_q <= vmem[vraddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_close && !zfull) begin
      zmem[zcnt_q[ZIDX_W-1:0]] <= '{zstart: open_start_q, zend: vcnt_q,
                                    flag: in_data_i.zone_flag};
    end
    if (cmd_i.zone_rd) begin
      zrd_q <= zmem[zidx_q[ZIDX_W-1:0]];
    end
  end

  // Edge test: yi/yj straddle py and one end lies at or left of px
  assign cond = ((vrd_q.y < py_q && prev_q.y >= py_q) ||
                 (prev_q.y < py_q && vrd_q.y >= py_q)) &&
                (vrd_q.x <= px_q || prev_q.x <= px_q);

  assign nl = (s3_nl_q) && (ml_q != 64'd0);
  assign nr = (s3_nr_q) && (mr_q != 64'd0);
  assign lt = s3_dpos_q ? slt(nl, ml_q, nr, mr_q) : slt(nr, mr_q, nl, ml_q);

  // Payload pipeline: differences, magnitudes, products
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      px_q <= in_data_i.point_x;
      py_q <= in_data_i.point_y;
    end
    if (vrd_v_q) begin
      prev_q <= vrd_q;
    end
    s1_cond_q <= cond;
    a_q       <= 33'(py_q) - 33'(vrd_q.y);
    b_q       <= 33'(prev_q.x) - 33'(vrd_q.x);
    c_q       <= 33'(px_q) - 33'(vrd_q.x);
    d_q       <= 33'(prev_q.y) - 33'(vrd_q.y);

    s2_cond_q <= s1_cond_q;
    am_q      <= abs33(a_q);
    bm_q      <= abs33(b_q);
    cm_q      <= abs33(c_q);
    dm_q      <= abs33(d_q);
    s2_nl_q   <= a_q[32] ^ b_q[32];
    s2_nr_q   <= c_q[32] ^ d_q[32];
    s2_dpos_q <= !d_q[32] && (d_q != 33'sd0);

    s3_cond_q <= s2_cond_q;
    ml_q      <= am_q * bm_q;
    mr_q      <= cm_q * dm_q;
    s3_nl_q   <= s2_nl_q;
    s3_nr_q   <= s2_nr_q;
    s3_dpos_q <= s2_dpos_q;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (is_other) begin
      out_q.result_flag <= 4'd0;
      out_q.found       <= 1'b0;
      if (is_append && vfull) begin
        out_q.status <= ST_VTX_FULL;
      end else if (is_close && zfull) begin
        out_q.status <= ST_ZONE_FULL;
      end else begin
        out_q.status <= ST_OK;
      end
    end else if (cmd_i.res_hit) begin
      out_q <= '{result_flag: zrd_q.flag, found: 1'b1, status: ST_OK};
    end else if (cmd_i.res_miss) begin
      out_q <= '{result_flag: unk_q, found: 1'b0, status: ST_OK};
    end
  end

  assign out_data_o = out_q;

  assign sts_o.zone_done  = zidx_q == zcnt_q;
  assign sts_o.zone_empty = zrd_q.zend <= zrd_q.zstart;
  assign sts_o.last_edge  = (vidx_q + VCNT_W'(1)) == zrd_q.zend;
  assign sts_o.pipe_busy  = vrd_v_q || s1_v_q || s2_v_q || s3_v_q;
  assign sts_o.in_zone    = odd_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= VCNT_W'(MAX_VERTICES))
    else $error("vertex count past store size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_start_q <= vcnt_q)
    else $error("open zone start past vertex count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.zone_rd |-> (zidx_q < zcnt_q))
    else $error("zone read beyond recorded zones");
`endif

endmodule

// ===== sv/pipz_ctrl.sv =====
module pipz_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  pipz_pkg::op_e        opcode_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  pipz_pkg::dp_sts_t    sts_i,
  output pipz_pkg::ctrl_cmd_t  cmd_o
);
  import pipz_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ZRD   = 7'b0000010,
    S_ZLD   = 7'b0000100,
    S_EDGE  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_HIT   = 7'b0100000,
    S_MISS  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && out_free) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == OP_QUERY) begin
            state_d = S_ZRD;
          end else begin
            load = 1'b1;
          end
        end
      end
      S_ZRD: begin
        if (sts_i.zone_done) begin
          state_d = S_MISS;
        end else begin
          cmd_o.zone_rd = 1'b1;
          state_d       = S_ZLD;
        end
      end
      S_ZLD: begin
        if (sts_i.zone_empty) begin
          cmd_o.zone_next = 1'b1;
          state_d         = S_ZRD;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd_o.edge_rd = 1'b1;
        if (sts_i.last_edge) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        // hold until the last edge has updated the parity
        if (!sts_i.pipe_busy) begin
          if (sts_i.in_zone) begin
            state_d = S_HIT;
          end else begin
            cmd_o.zone_next = 1'b1;
            state_d         = S_ZRD;
          end
        end
      end
      S_HIT: begin
        if (out_free) begin
          cmd_o.res_hit = 1'b1;
          load          = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          cmd_o.res_miss = 1'b1;
          load           = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_valid_q) |-> !out_stall_i)
    else $error("result overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDGE && sts_i.last_edge) |=> (state_q == S_DRAIN))
    else $error("edge walk did not end after last edge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && sts_i.pipe_busy) |=> (state_q == S_DRAIN))
    else $error("zone decided before edge pipeline drained");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input open during a query");
`endif

endmodule
